// ===== rtl/core/usjd_pkg.sv =====
// Package for the seconds-to-Julian-date converter: field widths, reciprocal
// constants for the pipelined constant divisions, and the small month tables.
// No dependencies; imported by unix_seconds_to_julian_date_top.
package usjd_pkg;

  // Field widths
  localparam int unsigned FRACTION_BITS = 32;
  localparam int unsigned EPOCH_BITS    = 38;
  localparam int unsigned SFRAC_BITS    = 32;
  localparam int unsigned JDAY_BITS     = 23;
  localparam int unsigned OUT_BITS      = FRACTION_BITS + JDAY_BITS;
  localparam int unsigned IN_TDATA_W    = ((EPOCH_BITS + SFRAC_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

  // Pipeline depth
  localparam int unsigned NUM_STAGES    = 16;

  // Day split: 86400 = 128 * 675, divide (secs >> 7) by 675
  localparam int unsigned SECX_BITS     = EPOCH_BITS - 7;
  localparam int unsigned DAYS_BITS     = 22;
  localparam int unsigned SOD_BITS      = 17;
  localparam int unsigned DAY_SHIFT     = SECX_BITS + 10;
  localparam logic [63:0] DAY_RECIP     = ((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675;
  localparam int unsigned DAY_PROD_W    = SECX_BITS + 32;
  localparam logic [9:0]  DIV_675       = 10'd675;

  // Civil-from-days constants
  localparam logic [DAYS_BITS-1:0] DAY_OFFSET = 22'd719468;
  localparam int unsigned ERA_BITS      = 5;
  localparam int unsigned ERA_SHIFT     = DAYS_BITS + 18;
  localparam logic [63:0] ERA_RECIP     = ((64'd1 << ERA_SHIFT) + 64'd146096) / 64'd146097;
  localparam int unsigned ERA_PROD_W    = DAYS_BITS + 23;
  localparam int unsigned EM_BITS       = 23;
  localparam logic [EM_BITS-1:0] DAYS_PER_ERA = 23'd146097;
  localparam int unsigned DOE_BITS      = 18;
  localparam logic [DOE_BITS-1:0] DOE_CENT1 = 18'd36524;
  localparam logic [DOE_BITS-1:0] DOE_CENT2 = 18'd73048;
  localparam logic [DOE_BITS-1:0] DOE_CENT3 = 18'd109572;
  localparam logic [DOE_BITS-1:0] DOE_LAST  = 18'd146096;
  localparam int unsigned Q4_SHIFT      = DOE_BITS + 11;
  localparam logic [63:0] Q4_RECIP      = ((64'd1 << Q4_SHIFT) + 64'd1459) / 64'd1460;
  localparam int unsigned YR_SHIFT      = DOE_BITS + 9;
  localparam logic [63:0] YR_RECIP      = ((64'd1 << YR_SHIFT) + 64'd364) / 64'd365;
  localparam int unsigned DOE_PROD_W    = DOE_BITS + 19;
  localparam int unsigned YOE_BITS      = 9;
  localparam int unsigned C100_SHIFT    = YOE_BITS + 7;
  localparam logic [63:0] C100_RECIP    = ((64'd1 << C100_SHIFT) + 64'd99) / 64'd100;
  localparam int unsigned C100_PROD_W   = YOE_BITS + 10;
  localparam int unsigned DOY_BITS      = 9;
  localparam int unsigned MPN_BITS      = 11;
  localparam int unsigned MP_SHIFT      = MPN_BITS + 8;
  localparam logic [63:0] MP_RECIP      = ((64'd1 << MP_SHIFT) + 64'd152) / 64'd153;
  localparam int unsigned MP_PROD_W     = MPN_BITS + 12;
  localparam logic [3:0]  MP_MARCH_END  = 4'd10;
  localparam int unsigned YEAR_BITS     = 14;
  localparam int unsigned S7_BITS       = 17;
  localparam logic [JDAY_BITS-1:0] DAY_NUMBER_BASE = 23'd1721013;

  // Time of day: num = second of day in units of 2^-FRACTION_BITS, then / 86400
  localparam int unsigned TUP           = (FRACTION_BITS > 32) ? FRACTION_BITS - 32 : 0;
  localparam int unsigned TDOWN         = (FRACTION_BITS < 32) ? 32 - FRACTION_BITS : 0;
  localparam int unsigned TX_BITS       = FRACTION_BITS + 10;
  localparam int unsigned TLO_BITS      = FRACTION_BITS / 2;
  localparam int unsigned THI_BITS      = TX_BITS - TLO_BITS;
  localparam int unsigned TQ1_BITS      = FRACTION_BITS - TLO_BITS;
  localparam int unsigned TX2_BITS      = 10 + TLO_BITS;
  localparam int unsigned TK1           = THI_BITS + 10;
  localparam int unsigned TK2           = TX2_BITS + 10;
  localparam logic [63:0] TRECIP1       = ((64'd1 << TK1) + 64'd674) / 64'd675;
  localparam logic [63:0] TRECIP2       = ((64'd1 << TK2) + 64'd674) / 64'd675;
  localparam int unsigned TP1_W         = 2 * THI_BITS + 1;
  localparam int unsigned TP2_W         = 2 * TX2_BITS + 1;

  // Days in the March-based year before month index mp: floor((153*mp+2)/5)
  function automatic logic [8:0] days_before_month(input logic [3:0] mp);
    logic [8:0] v;
    unique case (mp)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // Month term of the day-number formula: floor(275*m/9)
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] v;
    unique case (m)
      4'd1:    v = 9'd30;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd91;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd152;
      4'd6:    v = 9'd183;
      4'd7:    v = 9'd213;
      4'd8:    v = 9'd244;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd305;
      4'd11:   v = 9'd336;
      4'd12:   v = 9'd366;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/unix_seconds_to_julian_date_top.sv =====
// Top level of the seconds-to-Julian-date converter: a 16-stage pipeline that
// splits epoch seconds into date and time of day and forms the Julian date.
// Depends on usjd_pkg.
//
// Usage:
//   Slave stream carries one timestamp per transfer: epoch_seconds (whole
//   seconds since 1970-01-01 UTC) and second_fraction (binary fraction of a
//   second). Master stream returns one Julian date per timestamp as unsigned
//   fixed point with FRACTION_BITS fraction bits, truncated; the day number
//   uses the every-fourth-year-leap formula on the proleptic Gregorian date.
//   A slave transfer moves through the registers of every stage in order
//   before it is offered as a master transfer on m_axis_tvalid.
//   Throughput is one timestamp per cycle when nothing stalls; every
//   constant division is a reciprocal multiply, and the depth is set by the
//   chain day split -> era -> year of era -> month -> day number.
//   Each stage advances when it is empty or the stage after it advances, so
//   a stall on the master side fills bubbles first and only then drops
//   s_axis_tready; nothing is lost or repeated.
//   Reset empties the pipeline; s_axis_tready is high right after reset.
module unix_seconds_to_julian_date_top
  import usjd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [37:0] epoch_seconds, [69:38] second_fraction, rest zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [54:0] julian_date_fixed, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Stage valids and advance enables
  logic [NUM_STAGES:1]   vld_q;
  logic [NUM_STAGES:1]   vld_in;
  logic [NUM_STAGES:1]   en;

  // Advance stage i when any stage at or after i is empty, or output is taken
  always_comb begin
    for (int i = 1; i <= NUM_STAGES; i++) begin
      en[i] = m_axis_tready | (|((~vld_q) >> (i - 1)));
    end
  end

  assign vld_in        = {vld_q[NUM_STAGES-1:1], s_axis_tvalid};
  assign s_axis_tready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 1; i <= NUM_STAGES; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_in[i];
        end
      end
    end
  end

  // Input fields
  logic [EPOCH_BITS-1:0] in_secs;
  logic [SFRAC_BITS-1:0] in_frac;
  assign in_secs = s_axis_tdata[EPOCH_BITS-1:0];
  assign in_frac = s_axis_tdata[EPOCH_BITS +: SFRAC_BITS];

  // Stage registers
  logic [DAYS_BITS-1:0]  s1_days_q, s2_days_q;
  logic [EPOCH_BITS-1:0] s1_secs_q, s2_secs_q;
  logic [SFRAC_BITS-1:0] s1_frac_q, s2_frac_q, s3_frac_q;
  logic [31:0]           s2_dm_q;
  logic [SOD_BITS-1:0]   s3_sod_q;
  logic [DAYS_BITS-1:0]  s3_z_q, s4_z_q, s5_z_q;
  logic [ERA_BITS-1:0]   s4_era_q, s5_era_q, s6_era_q, s7_era_q, s8_era_q, s9_era_q;
  logic [ERA_BITS-1:0]   s10_era_q;
  logic [EM_BITS-1:0]    s5_em_q;
  logic [TQ1_BITS-1:0]   s4_tq1_q, s5_tq1_q, s6_tq1_q;
  logic [THI_BITS-1:0]   s4_thi_q, s5_thi_q;
  logic [TLO_BITS-1:0]   s4_tlo_q, s5_tlo_q;
  logic [THI_BITS-1:0]   s5_tq1m_q;
  logic [TX2_BITS-1:0]   s6_tx2_q;
  logic [DOE_BITS-1:0]   s6_doe_q, s7_doe_q, s8_doe_q, s9_doe_q, s10_doe_q;
  logic [6:0]            s7_a_q;
  logic [2:0]            s7_b_q;
  logic                  s7_c_q;
  logic [FRACTION_BITS-1:0] s7_tq_q, s8_tq_q, s9_tq_q, s10_tq_q, s11_tq_q, s12_tq_q;
  logic [FRACTION_BITS-1:0] s13_tq_q, s14_tq_q, s15_tq_q;
  logic [DOE_BITS-1:0]   s8_t_q;
  logic [YOE_BITS-1:0]   s9_yoe_q, s10_yoe_q;
  logic [DOE_BITS-1:0]   s10_m365_q;
  logic [1:0]            s10_c100_q;
  logic [DOY_BITS-1:0]   s11_doy_q, s12_doy_q;
  logic [YEAR_BITS-1:0]  s11_yb_q, s12_yb_q, s13_y_q;
  logic [3:0]            s12_mp_q, s13_m_q;
  logic [4:0]            s13_d_q;
  logic                  s13_late_q;
  logic [JDAY_BITS-1:0]  s14_a367_q;
  logic [S7_BITS-3:0]    s14_s7_q;
  logic [8:0]            s14_md_q;
  logic [JDAY_BITS-1:0]  s15_jday_q;
  logic [OUT_BITS-1:0]   s16_res_q;

  // Stage 1: days = (secs >> 7) / 675 by reciprocal
  logic [DAY_PROD_W-1:0] day_prod;
  assign day_prod = DAY_PROD_W'(in_secs[EPOCH_BITS-1:7]) * DAY_PROD_W'(DAY_RECIP[31:0]);

  // Stage 3: second of day and shifted day count
  logic [SECX_BITS-1:0] day_rem;
  assign day_rem = s2_secs_q[EPOCH_BITS-1:7] - s2_dm_q[SECX_BITS-1:0];

  // Stage 4: era by reciprocal; time of day scaled and split for long division
  logic [ERA_PROD_W-1:0] era_prod;
  logic [63:0]           tfix;
  logic [63:0]           tnum;
  logic [TX_BITS-1:0]    tx;
  logic [TP1_W-1:0]      tp1;
  assign era_prod = ERA_PROD_W'(s3_z_q) * ERA_PROD_W'(ERA_RECIP[22:0]);
  assign tfix     = {{(64 - SOD_BITS - SFRAC_BITS){1'b0}}, s3_sod_q, s3_frac_q};
  assign tnum     = (tfix << TUP) >> TDOWN;
  assign tx       = tnum[7 +: TX_BITS];
  assign tp1      = TP1_W'(tx[TLO_BITS +: THI_BITS]) * TP1_W'(TRECIP1[THI_BITS:0]);

  // Stage 6: day of era; remainder of the upper time digit
  logic [EM_BITS-1:0]  doe_full;
  logic [THI_BITS-1:0] trem;
  assign doe_full = EM_BITS'(s5_z_q) - s5_em_q;
  assign trem     = s5_thi_q - s5_tq1m_q;

  // Stage 7: century and four-year corrections; lower time digit
  logic [DOE_PROD_W-1:0] q4_prod;
  logic [TP2_W-1:0]      tp2;
  assign q4_prod = DOE_PROD_W'(s6_doe_q) * DOE_PROD_W'(Q4_RECIP[18:0]);
  assign tp2     = TP2_W'(s6_tx2_q) * TP2_W'(TRECIP2[TX2_BITS:0]);

  // Stage 9: year of era
  logic [DOE_PROD_W-1:0] yr_prod;
  assign yr_prod = DOE_PROD_W'(s8_t_q) * DOE_PROD_W'(YR_RECIP[18:0]);

  // Stage 10: year-of-era day count terms
  logic [C100_PROD_W-1:0] c100_prod;
  assign c100_prod = C100_PROD_W'(s9_yoe_q) * C100_PROD_W'(C100_RECIP[9:0]);

  // Stage 11: day of year, base year
  logic [DOE_BITS-1:0] yr_days;
  logic [DOE_BITS-1:0] doy_full;
  assign yr_days  = s10_m365_q + DOE_BITS'(s10_yoe_q >> 2) - DOE_BITS'(s10_c100_q);
  assign doy_full = s10_doe_q - yr_days;

  // Stage 12: March-based month index
  logic [MPN_BITS-1:0]  mp_num;
  logic [MP_PROD_W-1:0] mp_prod;
  assign mp_num  = (MPN_BITS'(s11_doy_q) << 2) + MPN_BITS'(s11_doy_q) + MPN_BITS'(2);
  assign mp_prod = MP_PROD_W'(mp_num) * MP_PROD_W'(MP_RECIP[11:0]);

  // Stage 13: month, day, year
  logic [DOY_BITS-1:0] day_full;
  logic                mp_late;
  assign mp_late  = (s12_mp_q >= MP_MARCH_END);
  assign day_full = s12_doy_q - days_before_month(s12_mp_q) + DOY_BITS'(1);

  // Stage 14: formula terms
  logic [S7_BITS-1:0] s7_full;
  assign s7_full = (S7_BITS'(s13_y_q) + S7_BITS'(!s13_late_q)) * S7_BITS'(7);

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_days_q <= day_prod[DAY_SHIFT +: DAYS_BITS];
      s1_secs_q <= in_secs;
      s1_frac_q <= in_frac;
    end
    if (en[2]) begin
      s2_dm_q   <= 32'(s1_days_q) * 32'(DIV_675);
      s2_days_q <= s1_days_q;
      s2_secs_q <= s1_secs_q;
      s2_frac_q <= s1_frac_q;
    end
    if (en[3]) begin
      s3_sod_q  <= {day_rem[9:0], s2_secs_q[6:0]};
      s3_z_q    <= s2_days_q + DAY_OFFSET;
      s3_frac_q <= s2_frac_q;
    end
    if (en[4]) begin
      s4_era_q <= era_prod[ERA_SHIFT +: ERA_BITS];
      s4_z_q   <= s3_z_q;
      s4_tq1_q <= tp1[TK1 +: TQ1_BITS];
      s4_thi_q <= tx[TLO_BITS +: THI_BITS];
      s4_tlo_q <= tx[TLO_BITS-1:0];
    end
    if (en[5]) begin
      s5_em_q   <= EM_BITS'(s4_era_q) * DAYS_PER_ERA;
      s5_z_q    <= s4_z_q;
      s5_era_q  <= s4_era_q;
      s5_tq1m_q <= THI_BITS'(s4_tq1_q) * THI_BITS'(DIV_675);
      s5_tq1_q  <= s4_tq1_q;
      s5_thi_q  <= s4_thi_q;
      s5_tlo_q  <= s4_tlo_q;
    end
    if (en[6]) begin
      s6_doe_q <= doe_full[DOE_BITS-1:0];
      s6_era_q <= s5_era_q;
      s6_tx2_q <= {trem[9:0], s5_tlo_q};
      s6_tq1_q <= s5_tq1_q;
    end
    if (en[7]) begin
      s7_a_q   <= q4_prod[Q4_SHIFT +: 7];
      s7_b_q   <= 3'(s6_doe_q >= DOE_CENT1) + 3'(s6_doe_q >= DOE_CENT2)
                + 3'(s6_doe_q >= DOE_CENT3) + 3'(s6_doe_q >= DOE_LAST);
      s7_c_q   <= (s6_doe_q == DOE_LAST);
      s7_doe_q <= s6_doe_q;
      s7_era_q <= s6_era_q;
      s7_tq_q  <= {s6_tq1_q, tp2[TK2 +: TLO_BITS]};
    end
    if (en[8]) begin
      s8_t_q   <= s7_doe_q - DOE_BITS'(s7_a_q) + DOE_BITS'(s7_b_q) - DOE_BITS'(s7_c_q);
      s8_doe_q <= s7_doe_q;
      s8_era_q <= s7_era_q;
      s8_tq_q  <= s7_tq_q;
    end
    if (en[9]) begin
      s9_yoe_q <= yr_prod[YR_SHIFT +: YOE_BITS];
      s9_doe_q <= s8_doe_q;
      s9_era_q <= s8_era_q;
      s9_tq_q  <= s8_tq_q;
    end
    if (en[10]) begin
      s10_m365_q <= DOE_BITS'(s9_yoe_q) * DOE_BITS'(365);
      s10_c100_q <= c100_prod[C100_SHIFT +: 2];
      s10_yoe_q  <= s9_yoe_q;
      s10_doe_q  <= s9_doe_q;
      s10_era_q  <= s9_era_q;
      s10_tq_q   <= s9_tq_q;
    end
    if (en[11]) begin
      s11_doy_q <= doy_full[DOY_BITS-1:0];
      s11_yb_q  <= YEAR_BITS'(s10_yoe_q) + YEAR_BITS'(s10_era_q) * YEAR_BITS'(400);
      s11_tq_q  <= s10_tq_q;
    end
    if (en[12]) begin
      s12_mp_q  <= mp_prod[MP_SHIFT +: 4];
      s12_doy_q <= s11_doy_q;
      s12_yb_q  <= s11_yb_q;
      s12_tq_q  <= s11_tq_q;
    end
    if (en[13]) begin
      s13_m_q    <= mp_late ? s12_mp_q - 4'd9 : s12_mp_q + 4'd3;
      s13_d_q    <= day_full[4:0];
      s13_y_q    <= s12_yb_q + YEAR_BITS'(mp_late);
      s13_late_q <= mp_late;
      s13_tq_q   <= s12_tq_q;
    end
    if (en[14]) begin
      s14_a367_q <= JDAY_BITS'(s13_y_q) * JDAY_BITS'(367);
      s14_s7_q   <= s7_full[S7_BITS-1:2];
      s14_md_q   <= month_offset(s13_m_q) + 9'(s13_d_q);
      s14_tq_q   <= s13_tq_q;
    end
    if (en[15]) begin
      s15_jday_q <= s14_a367_q - JDAY_BITS'(s14_s7_q) + JDAY_BITS'(s14_md_q)
                  + DAY_NUMBER_BASE;
      s15_tq_q   <= s14_tq_q;
    end
    if (en[16]) begin
      s16_res_q <= (OUT_BITS'(s15_jday_q) << FRACTION_BITS)
                 + (OUT_BITS'(1) << (FRACTION_BITS - 1))
                 + OUT_BITS'(s15_tq_q);
    end
  end

  // Output
  assign m_axis_tvalid = vld_q[NUM_STAGES];
  assign m_axis_tdata  = OUT_TDATA_W'(s16_res_q);

  // An empty output stage lets the whole pipeline advance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output stage is empty");

  // A full pipeline under output stall takes no new transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while every stage is full and stalled");

  // An accepted transfer occupies the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[1])
    else $error("accepted transfer missing from first stage");

endmodule
